// ===== design/nrt_pkg.sv =====
// Shared types, codes and sizes of the note retrigger tracker.
package nrt_pkg;

    localparam int PIPELINES = 64;
    localparam int PIPE_AW   = (PIPELINES > 1) ? $clog2(PIPELINES) : 1;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [CNT_W-1:0] CNT_MAX    = 8'hFF;
    localparam logic [7:0]       NO_PIPE    = 8'hFF;
    localparam logic [7:0]       NOTE_LIMIT = 8'd128;
    localparam logic [7:0]       PIPE_LIMIT = 8'(PIPELINES);

    // Event kinds.
    localparam logic [1:0] ACT_ON    = 2'd0;
    localparam logic [1:0] ACT_OFF   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Retrigger modes.
    localparam logic [1:0] MODE_IGNORE = 2'd0;
    localparam logic [1:0] MODE_RESET  = 2'd1;
    localparam logic [1:0] MODE_STACK  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_DONE        = 3'd0;
    localparam logic [2:0] ST_PANIC_DROP  = 3'd1;
    localparam logic [2:0] ST_BAD_NOTE    = 3'd2;
    localparam logic [2:0] ST_UNMAPPED    = 3'd3;
    localparam logic [2:0] ST_IGNORED     = 3'd4;
    localparam logic [2:0] ST_SPURIOUS    = 3'd5;
    localparam logic [2:0] ST_STACKED     = 3'd6;
    localparam logic [2:0] ST_OFF_REFUSED = 3'd7;

    // Off paths.
    localparam logic [1:0] OFF_NONE    = 2'd0;
    localparam logic [1:0] OFF_ACTIONS = 2'd1;
    localparam logic [1:0] OFF_DIRECT  = 2'd2;

    // LED events.
    localparam logic [1:0] LED_NONE = 2'd0;
    localparam logic [1:0] LED_ON   = 2'd1;
    localparam logic [1:0] LED_OFF  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PIPE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_ENABLE = 2'd1;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  note;
        logic [6:0]  velocity;
        logic [7:0]  pipeline_index;
        logic [1:0]  retrig_mode;
        logic        has_on_actions;
        logic        has_off_actions;
        logic        has_off_actuator;
        logic        sched_ready;
        logic        panic;
        logic [31:0] event_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [1:0]       off_kind;
        logic             fire_on;
        logic             on_via_actions;
        logic [1:0]       led_event;
        logic [7:0]       pipeline_out;
        logic [6:0]       note_out;
        logic [6:0]       velocity_out;
        logic [31:0]      time_out;
        logic [CNT_W-1:0] count_out;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

// ===== design/nrt_ifs.sv =====
// Handshake channel interfaces of the note retrigger tracker.
interface nrt_in_if import nrt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nrt_out_if import nrt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nrt_cfg_if import nrt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/note_retrigger_tracker.sv =====
// Top level of the note retrigger tracker: controller plus datapath.
//
// Usage:
//   i_in carries one note event word (action, note, velocity, pipeline index and
//   shape, scheduler readiness, panic, timestamp). Each accepted word yields
//   exactly one result word on o_out: status, off path, on path, LED event and
//   the pipeline's active-note counter after the event.
//   i_cfg writes the pipeline count (index 0) and led_enable (index 1); it is
//   ready from the first cycle after reset; the user must write it only while
//   no event is in flight, and the block itself does not enforce this.
// Timing:
//   The accepting edge captures an event and reads its counter from the
//   64-entry counter memory; the commit edge, taken once the output register
//   is free, decides, writes the counter back and loads the result word into
//   the output register. i_in.ready returns with the result, so a new event is
//   taken only after the last one is committed, a bound set by the
//   read-modify-write of the counter memory.
// Reset:
//   All counters read as zero (per-entry valid bits are cleared at once), both
//   configuration registers are zero, no result is pending, and i_in and i_cfg
//   hold ready low until the first cycle after reset.
// Stall:
//   While o_out waits on its receiver, one further event may be captured; it
//   then holds until the output register frees, and i_in.ready stays low.
module note_retrigger_tracker import nrt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nrt_in_if.sink    i_in,
    nrt_cfg_if.sink   i_cfg,
    nrt_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    nrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nrt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_in.data),
        .i_cfg       (i_cfg),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data),
        .i_out_ready (o_out.ready)
    );

endmodule

// ===== design/nrt_ctrl.sv =====
// Sequencing state machine: captures an event, then commits it to the output register.
module nrt_ctrl import nrt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid && r_in_ready;
        o_cmd.commit  = (r_state == S_EXEC) && i_stat.out_free;
    end

    assign o_in_ready = r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (i_stat.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== design/nrt_datapath.sv =====
// Counter store, event decision logic, configuration registers and output register.
module nrt_datapath import nrt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    input  t_in_item  i_item,
    nrt_cfg_if.sink   i_cfg,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_ready
);

    logic [CNT_W-1:0] mem_cnt [PIPELINES];
    logic [PIPELINES-1:0] r_cnt_vld;

    t_in_item         r_item;
    logic [CNT_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [6:0]       r_pipe_count;
    logic             r_led_en;
    logic             r_cfg_rdy;
    logic             r_out_vld;
    t_out_item        r_out;

    logic [PIPE_AW-1:0] rd_addr;
    logic [PIPE_AW-1:0] wr_addr;
    logic [CNT_W-1:0]   cur_cnt;
    logic [CNT_W-1:0]   base_cnt;
    logic [CNT_W-1:0]   wr_val;
    logic               wr_en;
    logic               clr_all;
    logic               mapped;
    logic               is_on;
    logic               sched;
    t_out_item          n_out;

    assign i_cfg.ready     = r_cfg_rdy;
    assign o_stat.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid     = r_out_vld;
    assign o_out_data      = r_out;

    // The event's own index is read in the capture cycle, the held one after.
    assign rd_addr = i_cmd.capture ? i_item.pipeline_index[PIPE_AW-1:0]
                                   : r_item.pipeline_index[PIPE_AW-1:0];
    assign wr_addr = r_item.pipeline_index[PIPE_AW-1:0];

    always_comb begin
        mapped  = (r_item.pipeline_index != NO_PIPE)
               && (r_item.pipeline_index < {1'b0, r_pipe_count})
               && (r_item.pipeline_index < PIPE_LIMIT);
        is_on   = (r_item.action == ACT_ON) && (r_item.velocity != '0);
        cur_cnt = r_rd_vld ? r_rd_data : '0;

        base_cnt = cur_cnt;
        wr_en    = 1'b0;
        wr_val   = cur_cnt;
        clr_all  = 1'b0;
        sched    = 1'b1;

        n_out                = '0;
        n_out.status         = ST_DONE;
        n_out.off_kind       = OFF_NONE;
        n_out.led_event      = LED_NONE;
        n_out.pipeline_out   = r_item.pipeline_index;
        n_out.note_out       = (r_item.note < NOTE_LIMIT) ? r_item.note[6:0] : '0;
        n_out.velocity_out   = r_item.velocity;
        n_out.time_out       = r_item.event_time;

        if (r_item.action == ACT_CLEAR) begin
            clr_all = 1'b1;
        end else if (r_item.action != ACT_ON && r_item.action != ACT_OFF) begin
            n_out.status = ST_IGNORED;
        end else if (r_item.panic && is_on) begin
            n_out.status = ST_PANIC_DROP;
        end else if (r_item.note >= NOTE_LIMIT) begin
            n_out.status = ST_BAD_NOTE;
        end else if (!mapped) begin
            n_out.status = ST_UNMAPPED;
        end else if (is_on) begin
            if (cur_cnt != '0 && r_item.retrig_mode == MODE_IGNORE) begin
                n_out.status = ST_IGNORED;
            end else begin
                if (cur_cnt != '0 && r_item.retrig_mode == MODE_RESET
                        && r_item.has_off_actions) begin
                    n_out.off_kind = OFF_ACTIONS;
                    base_cnt       = '0;
                end
                n_out.fire_on        = 1'b1;
                n_out.on_via_actions = r_item.has_on_actions;
                if (r_led_en) begin
                    n_out.led_event = LED_ON;
                end
                wr_en  = 1'b1;
                wr_val = (base_cnt == CNT_MAX) ? base_cnt : base_cnt + 1'b1;
            end
        end else begin
            if (cur_cnt == '0) begin
                n_out.status = ST_SPURIOUS;
            end else if (cur_cnt > 8'd1 && r_item.retrig_mode == MODE_STACK) begin
                wr_en        = 1'b1;
                wr_val       = cur_cnt - 1'b1;
                n_out.status = ST_STACKED;
            end else begin
                if (r_item.has_off_actions) begin
                    n_out.off_kind = OFF_ACTIONS;
                    sched          = r_item.sched_ready;
                end else if (r_item.has_off_actuator) begin
                    n_out.off_kind = OFF_DIRECT;
                    sched          = r_item.sched_ready;
                end
                wr_en = 1'b1;
                // A refused off leaves one note active so the next release retries.
                wr_val = sched ? '0 : 8'd1;
                if (!sched) begin
                    n_out.status = ST_OFF_REFUSED;
                end else if (r_led_en) begin
                    n_out.led_event = LED_OFF;
                end
            end
        end

        // A clear empties every counter, the addressed one included.
        n_out.count_out = (mapped && !clr_all) ? (wr_en ? wr_val : cur_cnt) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
        r_rd_data <= mem_cnt[rd_addr];
        if (i_cmd.commit && wr_en) begin
            mem_cnt[wr_addr] <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld    <= '0;
            r_rd_vld     <= 1'b0;
            r_pipe_count <= '0;
            r_led_en     <= 1'b0;
            r_cfg_rdy    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_cfg_rdy <= 1'b1;
            r_rd_vld  <= r_cnt_vld[rd_addr];
            if (i_cmd.commit && clr_all) begin
                r_cnt_vld <= '0;
            end else if (i_cmd.commit && wr_en) begin
                r_cnt_vld[wr_addr] <= 1'b1;
            end
            if (i_cfg.valid && r_cfg_rdy) begin
                unique case (i_cfg.index)
                    CFG_PIPE_COUNT: r_pipe_count <= i_cfg.data;
                    CFG_LED_ENABLE: r_led_en     <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(i_cmd.commit))
        else $error("result word appeared without a commit");

    a_fire_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.fire_on) |-> (r_out.status == ST_DONE && r_out.count_out != '0))
        else $error("note-on fired with a bad status or an empty counter");

    a_refused_keeps_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status == ST_OFF_REFUSED)
            |-> (r_out.count_out == 8'd1 && r_out.off_kind != OFF_NONE))
        else $error("refused off did not leave the counter at one");

    a_led_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.led_event != LED_NONE) |-> r_led_en)
        else $error("LED event raised while LED events are disabled");

endmodule
